@@ hdl/histogram_statistics_accumulator_defines.svh @@
// Assertion macros shared by the checker of the histogram statistics accumulator.
// Depends on a clk and an active-low rst_n in the scope where the macros are used.
`ifndef HISTOGRAM_STATISTICS_ACCUMULATOR_DEFINES_SVH
`define HISTOGRAM_STATISTICS_ACCUMULATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/hsa_pkg.sv @@
// Package of the histogram statistics accumulator: sizes, codes, shared types
// and the bin condition function. Used by every module of the block.
`timescale 1ns / 1ps

package hsa_pkg;

  localparam int MAX_BINS    = 256;
  localparam int COUNT_BITS  = 24;
  localparam int FRAC_BITS   = 8;
  localparam int BIN_IDX_W   = $clog2(MAX_BINS);
  localparam int SWEEP_W     = BIN_IDX_W + 1;
  localparam int BINS_W      = 9;
  localparam int SCALE_W     = 10;
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int SAMPLE_W    = 17;
  localparam int VALUE_W     = 16;
  localparam int SUM_W       = 40;
  localparam int PROB_W      = 18;
  localparam int POS_W       = BIN_IDX_W + FRAC_BITS + 2;
  localparam int MUL_W       = SCALE_W + COUNT_BITS;
  localparam int DVD_W       = MUL_W + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DVD_W + 1);
  localparam int BINS_RESET  = 256;
  localparam int SCALE_RESET = 100;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    COND_LT    = 3'd0,
    COND_LE    = 3'd1,
    COND_GT    = 3'd2,
    COND_GE    = 3'd3,
    COND_IN    = 3'd4,
    COND_OUT   = 3'd5,
    COND_EQ    = 3'd6,
    COND_NEVER = 3'd7
  } cond_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BINS  = 1'b0,
    REG_SCALE = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD_WR,
    ST_SWEEP,
    ST_MUL,
    ST_MEAN_WAIT,
    ST_PROB_GO,
    ST_PROB_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } bin_cmd_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quo;
  } div_res_t;

  function automatic logic bin_hit(input logic [BIN_IDX_W-1:0] idx,
                                   input logic [2:0] cond,
                                   input logic signed [SAMPLE_W-1:0] lo,
                                   input logic signed [SAMPLE_W-1:0] hi);
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] lo_x;
    logic signed [POS_W-1:0] hi_x;
    logic                    hit;
    pos  = $signed({2'b00, idx, {FRAC_BITS{1'b0}}});
    lo_x = POS_W'(lo);
    hi_x = POS_W'(hi);
    case (cond)
      COND_LT:  hit = pos < lo_x;
      COND_LE:  hit = pos <= lo_x;
      COND_GT:  hit = pos > lo_x;
      COND_GE:  hit = pos >= lo_x;
      COND_IN:  hit = (pos >= lo_x) && (pos < hi_x);
      COND_OUT: hit = (pos < lo_x) || (pos > hi_x);
      COND_EQ:  hit = pos == lo_x;
      default:  hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

@@ hdl/hsa_bin_store.sv @@
// Histogram bin memory with one write and one registered read port, plus
// per-bin valid flags that make unwritten bins read as zero. Uses hsa_pkg.
`timescale 1ns / 1ps

module hsa_bin_store (
  input  logic                               clk,
  input  logic                               rst_n,
  input  hsa_pkg::bin_cmd_t                  cmd,
  input  logic [hsa_pkg::BIN_IDX_W-1:0]      rd_addr,
  input  logic [hsa_pkg::BIN_IDX_W-1:0]      wr_addr,
  input  logic [hsa_pkg::COUNT_BITS-1:0]     wr_data,
  output logic [hsa_pkg::COUNT_BITS-1:0]     rd_value
);

  logic [hsa_pkg::COUNT_BITS-1:0] mem [hsa_pkg::MAX_BINS];
  logic [hsa_pkg::MAX_BINS-1:0]   valid_r;
  logic [hsa_pkg::COUNT_BITS-1:0] rd_data_r;
  logic                           rd_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        valid_r <= '0;
      end else if (cmd.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_value = rd_vld_r ? rd_data_r : '0;

endmodule

@@ hdl/hsa_divider.sv @@
// Restoring divider that produces one quotient bit per cycle, shared by the
// mean and probability calculations. Uses hsa_pkg.
`timescale 1ns / 1ps

module hsa_divider (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [hsa_pkg::DVD_W-1:0]          dividend,
  input  logic [hsa_pkg::COUNT_BITS-1:0]     divisor,
  output hsa_pkg::div_res_t                  res
);

  logic [hsa_pkg::DVD_W-1:0]      quo_r;
  logic [hsa_pkg::COUNT_BITS:0]   rem_r;
  logic [hsa_pkg::COUNT_BITS-1:0] dsr_r;
  logic [hsa_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [hsa_pkg::COUNT_BITS:0]   rem_sh;
  logic [hsa_pkg::COUNT_BITS:0]   rem_diff;
  logic                           ge;

  assign rem_sh   = {rem_r[hsa_pkg::COUNT_BITS-1:0], quo_r[hsa_pkg::DVD_W-1]};
  assign ge       = rem_sh >= {1'b0, dsr_r};
  assign rem_diff = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[hsa_pkg::DVD_W-2:0], ge};
      rem_r <= ge ? rem_diff : rem_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= hsa_pkg::DIV_CNT_W'(hsa_pkg::DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == hsa_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;

endmodule

@@ hdl/histogram_statistics_accumulator.sv @@
// Histogram statistics accumulator: sequencer, statistics registers and result
// register. Uses hsa_pkg, hsa_bin_store and hsa_divider.
//
// Usage: items arrive on the in_ channel (valid/stall) and each one gives
// exactly one result transfer on the out_ channel. One item is worked on at a
// time. An accepted add goes through decode with bin read, bin write, result
// load and the output transfer. A rejected add, a clear, an unused code and a
// query with no samples go through decode, result load and the output transfer.
// A query with samples goes through decode, a sweep over bins_in_use bins
// (capped at 256) with one extra step for the last read, a multiply step that
// starts the divider, two divider passes at one quotient bit per cycle (mean,
// then probability) with a start state between them, result load and the
// output transfer. A finished result sits in the output register; the next
// item is taken while it waits, but its result is only loaded once the
// receiver has taken the previous one, so out_stall holds the result steady
// and then stalls the input. Configuration writes on cfg_ take effect at once;
// the user must make them only while the block is idle, which the block itself
// does not enforce. Synchronous reset restores bins_in_use to 256 and
// prob_scale to 100 and clears all statistics and the bin valid flags.
`timescale 1ns / 1ps

module histogram_statistics_accumulator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_op,
  input  logic signed [hsa_pkg::SAMPLE_W-1:0]  in_sample_value,
  input  logic [2:0]                           in_condition,
  input  logic signed [hsa_pkg::SAMPLE_W-1:0]  in_lower_limit,
  input  logic signed [hsa_pkg::SAMPLE_W-1:0]  in_upper_limit,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_accepted,
  output logic                                 out_empty_res,
  output logic [hsa_pkg::VALUE_W-1:0]          out_min_value,
  output logic [hsa_pkg::VALUE_W-1:0]          out_max_value,
  output logic [hsa_pkg::VALUE_W-1:0]          out_mean_value,
  output logic [hsa_pkg::PROB_W-1:0]           out_probability,
  output logic [hsa_pkg::COUNT_BITS-1:0]       out_sample_count,
  input  logic                                 cfg_we,
  input  logic [hsa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hsa_pkg::CFG_W-1:0]            cfg_wdata
);

  hsa_pkg::state_t state_r, state_nxt;

  logic [1:0]                          op_r;
  logic signed [hsa_pkg::SAMPLE_W-1:0] sample_r;
  logic [2:0]                          cond_r;
  logic signed [hsa_pkg::SAMPLE_W-1:0] lo_r;
  logic signed [hsa_pkg::SAMPLE_W-1:0] hi_r;

  logic [hsa_pkg::BINS_W-1:0]     bins_r;
  logic [hsa_pkg::SCALE_W-1:0]    scale_r;
  logic [hsa_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic [hsa_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [hsa_pkg::VALUE_W-1:0]    min_r, min_nxt;
  logic [hsa_pkg::VALUE_W-1:0]    max_r, max_nxt;

  logic [hsa_pkg::SWEEP_W-1:0]    idx_r, idx_nxt;
  logic                           pend_v_r, pend_v_nxt;
  logic                           pend_hit_r, pend_hit_nxt;
  logic [hsa_pkg::COUNT_BITS-1:0] hits_r, hits_nxt;
  logic [hsa_pkg::DVD_W-1:0]      prod_r, prod_nxt;
  logic [hsa_pkg::VALUE_W-1:0]    mean_r, mean_nxt;
  logic [hsa_pkg::PROB_W-1:0]     prob_r, prob_nxt;
  logic                           res_acc_r, res_acc_nxt;
  logic                           res_q_r, res_q_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic                           out_acc_r;
  logic                           out_empty_r;
  logic [hsa_pkg::VALUE_W-1:0]    out_min_r;
  logic [hsa_pkg::VALUE_W-1:0]    out_max_r;
  logic [hsa_pkg::VALUE_W-1:0]    out_mean_r;
  logic [hsa_pkg::PROB_W-1:0]     out_prob_r;
  logic [hsa_pkg::COUNT_BITS-1:0] out_count_r;

  logic [hsa_pkg::BINS_W-1:0]     bins_eff;
  logic [hsa_pkg::VALUE_W-1:0]    uv;
  logic [hsa_pkg::BIN_IDX_W-1:0]  sample_bin;
  logic                           add_ok;
  logic                           sweep_more;
  logic                           in_xfer;
  logic                           out_free;
  logic                           load_out;
  logic [hsa_pkg::MUL_W-1:0]      mul_c;

  hsa_pkg::bin_cmd_t              bin_cmd;
  logic [hsa_pkg::BIN_IDX_W-1:0]  bin_rd_addr;
  logic [hsa_pkg::COUNT_BITS-1:0] bin_value;
  logic [hsa_pkg::COUNT_BITS-1:0] bin_wr_data;
  logic                           div_start;
  logic [hsa_pkg::DVD_W-1:0]      div_dividend;
  hsa_pkg::div_res_t              div_res;

  assign bins_eff   = (bins_r > hsa_pkg::BINS_W'(hsa_pkg::MAX_BINS)) ?
                      hsa_pkg::BINS_W'(hsa_pkg::MAX_BINS) : bins_r;
  assign uv         = sample_r[hsa_pkg::VALUE_W-1:0];
  assign sample_bin = uv[hsa_pkg::FRAC_BITS +: hsa_pkg::BIN_IDX_W];
  assign add_ok     = !sample_r[hsa_pkg::SAMPLE_W-1] &&
                      (hsa_pkg::BINS_W'(sample_bin) < bins_eff) &&
                      (count_r != '1);
  assign sweep_more = hsa_pkg::BINS_W'(idx_r) < bins_eff;
  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign mul_c      = hsa_pkg::MUL_W'(scale_r) * hsa_pkg::MUL_W'(hits_r);
  assign bin_wr_data = bin_value + 1'b1;

  hsa_bin_store u_bins (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (bin_cmd),
    .rd_addr  (bin_rd_addr),
    .wr_addr  (sample_bin),
    .wr_data  (bin_wr_data),
    .rd_value (bin_value)
  );

  hsa_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count_r),
    .res      (div_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hsa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = hsa_pkg::ST_DISPATCH;
        end
      end
      hsa_pkg::ST_DISPATCH: begin
        case (op_r)
          hsa_pkg::OP_ADD:   state_nxt = add_ok ? hsa_pkg::ST_ADD_WR : hsa_pkg::ST_DONE;
          hsa_pkg::OP_QUERY: state_nxt = (count_r != '0) ? hsa_pkg::ST_SWEEP :
                                                          hsa_pkg::ST_DONE;
          default:           state_nxt = hsa_pkg::ST_DONE;
        endcase
      end
      hsa_pkg::ST_ADD_WR:    state_nxt = hsa_pkg::ST_DONE;
      hsa_pkg::ST_SWEEP: begin
        if (!sweep_more) begin
          state_nxt = hsa_pkg::ST_MUL;
        end
      end
      hsa_pkg::ST_MUL:       state_nxt = hsa_pkg::ST_MEAN_WAIT;
      hsa_pkg::ST_MEAN_WAIT: begin
        if (div_res.done) begin
          state_nxt = hsa_pkg::ST_PROB_GO;
        end
      end
      hsa_pkg::ST_PROB_GO:   state_nxt = hsa_pkg::ST_PROB_WAIT;
      hsa_pkg::ST_PROB_WAIT: begin
        if (div_res.done) begin
          state_nxt = hsa_pkg::ST_DONE;
        end
      end
      hsa_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = hsa_pkg::ST_IDLE;
        end
      end
      default:               state_nxt = hsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    bin_cmd      = '0;
    bin_rd_addr  = idx_r[hsa_pkg::BIN_IDX_W-1:0];
    div_start    = 1'b0;
    div_dividend = prod_r;
    load_out     = 1'b0;
    unique case (state_r)
      hsa_pkg::ST_IDLE:     in_stall = 1'b0;
      hsa_pkg::ST_DISPATCH: begin
        bin_rd_addr = sample_bin;
        if (op_r == hsa_pkg::OP_ADD) begin
          bin_cmd.rd_en = add_ok;
        end
        if (op_r == hsa_pkg::OP_CLEAR) begin
          bin_cmd.clr = 1'b1;
        end
      end
      hsa_pkg::ST_ADD_WR:   bin_cmd.wr_en = 1'b1;
      hsa_pkg::ST_SWEEP:    bin_cmd.rd_en = sweep_more;
      hsa_pkg::ST_MUL: begin
        div_start    = 1'b1;
        div_dividend = hsa_pkg::DVD_W'(sum_r);
      end
      hsa_pkg::ST_PROB_GO:  div_start = 1'b1;
      hsa_pkg::ST_DONE:     load_out = out_free;
      default: begin
      end
    endcase
  end

  always_comb begin
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    idx_nxt      = idx_r;
    pend_v_nxt   = 1'b0;
    pend_hit_nxt = 1'b0;
    hits_nxt     = hits_r;
    prod_nxt     = prod_r;
    mean_nxt     = mean_r;
    prob_nxt     = prob_r;
    res_acc_nxt  = res_acc_r;
    res_q_nxt    = res_q_r;
    case (state_r)
      hsa_pkg::ST_DISPATCH: begin
        res_acc_nxt = 1'b0;
        res_q_nxt   = 1'b0;
        idx_nxt     = '0;
        hits_nxt    = '0;
        if (op_r == hsa_pkg::OP_CLEAR) begin
          count_nxt = '0;
          sum_nxt   = '0;
          min_nxt   = '1;
          max_nxt   = '0;
        end
        if (op_r == hsa_pkg::OP_QUERY) begin
          res_q_nxt = count_r != '0;
        end
      end
      hsa_pkg::ST_ADD_WR: begin
        res_acc_nxt = 1'b1;
        count_nxt   = count_r + 1'b1;
        sum_nxt     = sum_r + hsa_pkg::SUM_W'(uv);
        if (uv > max_r) begin
          max_nxt = uv;
        end
        if (uv < min_r) begin
          min_nxt = uv;
        end
      end
      hsa_pkg::ST_SWEEP: begin
        if (pend_v_r && pend_hit_r) begin
          hits_nxt = hits_r + bin_value;
        end
        if (sweep_more) begin
          pend_v_nxt   = 1'b1;
          pend_hit_nxt = hsa_pkg::bin_hit(idx_r[hsa_pkg::BIN_IDX_W-1:0], cond_r,
                                          lo_r, hi_r);
          idx_nxt      = idx_r + 1'b1;
        end
      end
      hsa_pkg::ST_MUL: begin
        prod_nxt = hsa_pkg::DVD_W'(mul_c) << hsa_pkg::FRAC_BITS;
      end
      hsa_pkg::ST_MEAN_WAIT: begin
        if (div_res.done) begin
          mean_nxt = div_res.quo[hsa_pkg::VALUE_W-1:0];
        end
      end
      hsa_pkg::ST_PROB_WAIT: begin
        if (div_res.done) begin
          prob_nxt = (|div_res.quo[hsa_pkg::DVD_W-1:hsa_pkg::PROB_W]) ? '1 :
                     div_res.quo[hsa_pkg::PROB_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hsa_pkg::ST_IDLE;
      bins_r      <= hsa_pkg::BINS_W'(hsa_pkg::BINS_RESET);
      scale_r     <= hsa_pkg::SCALE_W'(hsa_pkg::SCALE_RESET);
      count_r     <= '0;
      sum_r       <= '0;
      min_r       <= '1;
      max_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          hsa_pkg::REG_BINS:  bins_r  <= cfg_wdata[hsa_pkg::BINS_W-1:0];
          hsa_pkg::REG_SCALE: scale_r <= cfg_wdata[hsa_pkg::SCALE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r     <= in_op;
      sample_r <= in_sample_value;
      cond_r   <= in_condition;
      lo_r     <= in_lower_limit;
      hi_r     <= in_upper_limit;
    end
    idx_r      <= idx_nxt;
    pend_hit_r <= pend_hit_nxt;
    hits_r     <= hits_nxt;
    prod_r     <= prod_nxt;
    mean_r     <= mean_nxt;
    prob_r     <= prob_nxt;
    res_acc_r  <= res_acc_nxt;
    res_q_r    <= res_q_nxt;
    if (load_out) begin
      out_acc_r   <= res_acc_r;
      out_empty_r <= count_r == '0;
      out_min_r   <= res_q_r ? min_r : '0;
      out_max_r   <= res_q_r ? max_r : '0;
      out_mean_r  <= res_q_r ? mean_r : '0;
      out_prob_r  <= res_q_r ? prob_r : '0;
      out_count_r <= count_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_acc_r;
  assign out_empty_res    = out_empty_r;
  assign out_min_value    = out_min_r;
  assign out_max_value    = out_max_r;
  assign out_mean_value   = out_mean_r;
  assign out_probability  = out_prob_r;
  assign out_sample_count = out_count_r;

endmodule

@@ hdl/hsa_checker.sv @@
// Port-level checker of the histogram statistics accumulator and its bind.
// Depends on hsa_pkg and the macros in histogram_statistics_accumulator_defines.svh.
`timescale 1ns / 1ps
`include "histogram_statistics_accumulator_defines.svh"

module hsa_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 out_accepted,
  input logic                                 out_empty_res,
  input logic [hsa_pkg::VALUE_W-1:0]          out_mean_value,
  input logic [hsa_pkg::PROB_W-1:0]           out_probability,
  input logic [hsa_pkg::COUNT_BITS-1:0]       out_sample_count
);

  `HSA_ASSERT_NEXT(a_busy_after_xfer, in_valid && !in_stall, in_stall,
                   "input taken while the previous item is still in progress")

  `HSA_ASSERT_NOW(a_empty_matches_count, out_valid,
                  out_empty_res == (out_sample_count == '0),
                  "empty flag disagrees with the sample count")

  `HSA_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid && $stable(out_sample_count),
                   "stalled result dropped or changed")

  `HSA_ASSERT_NOW(a_empty_stats_zero, out_valid && out_empty_res,
                  out_mean_value == '0 && out_probability == '0 && !out_accepted,
                  "empty result carries nonzero statistics")

endmodule

bind histogram_statistics_accumulator hsa_checker u_hsa_checker (.*);

@@ tb/histogram_statistics_accumulator_test.sv @@
// Self-checking testbench for histogram_statistics_accumulator: directed and random
// sample, clear and query transfers checked against a predictor in a scoreboard class.
// Depends on hsa_pkg and the histogram_statistics_accumulator RTL.
`timescale 1ns / 1ps

module histogram_statistics_accumulator_test;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int LONG_HOLD = 300;
  localparam int TAIL_CYCLES = 400;
  localparam int BINS_TAB [PHASES] = '{1, 2, 511, 0, 16, 256, -1, 100};
  localparam int SCALE_TAB [PHASES] = '{1000, 0, 1023, 100, 1, 1000, -1, 37};

  typedef struct packed {
    logic                           accepted;
    logic                           empty_res;
    logic [hsa_pkg::VALUE_W-1:0]    min_value;
    logic [hsa_pkg::VALUE_W-1:0]    max_value;
    logic [hsa_pkg::VALUE_W-1:0]    mean_value;
    logic [hsa_pkg::PROB_W-1:0]     probability;
    logic [hsa_pkg::COUNT_BITS-1:0] sample_count;
  } stats_t;

  class stats_scoreboard;
    logic [hsa_pkg::COUNT_BITS-1:0] bin_count [hsa_pkg::MAX_BINS];
    logic [hsa_pkg::COUNT_BITS-1:0] total;
    logic [hsa_pkg::SUM_W-1:0]      value_total;
    logic [hsa_pkg::VALUE_W-1:0]    low_seen;
    logic [hsa_pkg::VALUE_W-1:0]    high_seen;
    logic [hsa_pkg::BINS_W-1:0]     bins_reg;
    logic [hsa_pkg::SCALE_W-1:0]    scale_reg;
    stats_t                         due[$];
    int                             errors;
    int                             items;
    int                             added;
    int                             queried;
    int                             results;

    function new();
      errors = 0;
      items = 0;
      added = 0;
      queried = 0;
      results = 0;
      bins_reg = hsa_pkg::BINS_W'(hsa_pkg::BINS_RESET);
      scale_reg = hsa_pkg::SCALE_W'(hsa_pkg::SCALE_RESET);
      clear_stats();
    endfunction

    function void clear_stats();
      foreach (bin_count[i]) bin_count[i] = '0;
      total = '0;
      value_total = '0;
      low_seen = '1;
      high_seen = '0;
    endfunction

    function void write_reg(hsa_pkg::cfg_reg_t idx, logic [hsa_pkg::CFG_W-1:0] data);
      if (idx == hsa_pkg::REG_BINS) bins_reg = data[hsa_pkg::BINS_W-1:0];
      else scale_reg = data[hsa_pkg::SCALE_W-1:0];
    endfunction

    function int active_bins();
      return (bins_reg > hsa_pkg::MAX_BINS) ? hsa_pkg::MAX_BINS : int'(bins_reg);
    endfunction

    function void note_input(logic [1:0] op, logic signed [hsa_pkg::SAMPLE_W-1:0] value,
                             logic [2:0] cond, logic signed [hsa_pkg::SAMPLE_W-1:0] lo,
                             logic signed [hsa_pkg::SAMPLE_W-1:0] hi);
      stats_t          r;
      int              v;
      int              pos;
      int              lo_i;
      int              hi_i;
      logic            hit;
      longint unsigned hits;
      longint unsigned prob;
      r = '0;
      items++;
      if (op == hsa_pkg::OP_ADD) begin
        v = int'(value);
        if (v >= 0 && v < (active_bins() << hsa_pkg::FRAC_BITS) &&
            total != {hsa_pkg::COUNT_BITS{1'b1}}) begin
          r.accepted = 1'b1;
          added++;
          total++;
          value_total = value_total + hsa_pkg::SUM_W'(v);
          if (v[hsa_pkg::VALUE_W-1:0] > high_seen) high_seen = v[hsa_pkg::VALUE_W-1:0];
          if (v[hsa_pkg::VALUE_W-1:0] < low_seen) low_seen = v[hsa_pkg::VALUE_W-1:0];
          bin_count[v >> hsa_pkg::FRAC_BITS]++;
        end
      end else if (op == hsa_pkg::OP_CLEAR) begin
        clear_stats();
      end else if (op == hsa_pkg::OP_QUERY && total != 0) begin
        queried++;
        lo_i = int'(lo);
        hi_i = int'(hi);
        hits = 0;
        for (int i = 0; i < active_bins(); i++) begin
          pos = i << hsa_pkg::FRAC_BITS;
          case (hsa_pkg::cond_t'(cond))
            hsa_pkg::COND_LT:  hit = pos < lo_i;
            hsa_pkg::COND_LE:  hit = pos <= lo_i;
            hsa_pkg::COND_GT:  hit = pos > lo_i;
            hsa_pkg::COND_GE:  hit = pos >= lo_i;
            hsa_pkg::COND_IN:  hit = (pos >= lo_i) && (pos < hi_i);
            hsa_pkg::COND_OUT: hit = (pos < lo_i) || (pos > hi_i);
            hsa_pkg::COND_EQ:  hit = pos == lo_i;
            default:           hit = 1'b0;
          endcase
          if (hit) hits += 64'(bin_count[i]);
        end
        r.min_value = low_seen;
        r.max_value = high_seen;
        r.mean_value = hsa_pkg::VALUE_W'(value_total / hsa_pkg::SUM_W'(total));
        prob = (64'(scale_reg) * hits * (64'd1 << hsa_pkg::FRAC_BITS)) / 64'(total);
        if (prob > 64'h3FFFF) prob = 64'h3FFFF;
        r.probability = hsa_pkg::PROB_W'(prob);
      end
      r.empty_res = (total == 0);
      r.sample_count = total;
      due.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 20) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s is %0h, expected %0h in result %0d", name, got, want, results));
    endtask

    task check_result(stats_t got);
      stats_t want;
      results++;
      if (due.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", results));
        return;
      end
      want = due.pop_front();
      check_field("accepted", 32'(got.accepted), 32'(want.accepted));
      check_field("empty_res", 32'(got.empty_res), 32'(want.empty_res));
      check_field("min_value", 32'(got.min_value), 32'(want.min_value));
      check_field("max_value", 32'(got.max_value), 32'(want.max_value));
      check_field("mean_value", 32'(got.mean_value), 32'(want.mean_value));
      check_field("probability", 32'(got.probability), 32'(want.probability));
      check_field("sample_count", 32'(got.sample_count), 32'(want.sample_count));
    endtask
  endclass

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic [1:0]                           in_op = '0;
  logic signed [hsa_pkg::SAMPLE_W-1:0]  in_sample_value = '0;
  logic [2:0]                           in_condition = '0;
  logic signed [hsa_pkg::SAMPLE_W-1:0]  in_lower_limit = '0;
  logic signed [hsa_pkg::SAMPLE_W-1:0]  in_upper_limit = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic                                 out_accepted;
  logic                                 out_empty_res;
  logic [hsa_pkg::VALUE_W-1:0]          out_min_value;
  logic [hsa_pkg::VALUE_W-1:0]          out_max_value;
  logic [hsa_pkg::VALUE_W-1:0]          out_mean_value;
  logic [hsa_pkg::PROB_W-1:0]           out_probability;
  logic [hsa_pkg::COUNT_BITS-1:0]       out_sample_count;
  logic                                 cfg_we = 1'b0;
  logic [hsa_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
  logic [hsa_pkg::CFG_W-1:0]            cfg_wdata = '0;

  logic tx_idle_on = 1'b0;
  logic rx_idle_on = 1'b0;
  logic hold_req = 1'b0;

  stats_scoreboard sb = new();

  histogram_statistics_accumulator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_sample_value  (in_sample_value),
    .in_condition     (in_condition),
    .in_lower_limit   (in_lower_limit),
    .in_upper_limit   (in_upper_limit),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_empty_res    (out_empty_res),
    .out_min_value    (out_min_value),
    .out_max_value    (out_max_value),
    .out_mean_value   (out_mean_value),
    .out_probability  (out_probability),
    .out_sample_count (out_sample_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin : monitor
    stats_t seen;
    if (rst_n && in_valid && !in_stall)
      sb.note_input(in_op, in_sample_value, in_condition, in_lower_limit, in_upper_limit);
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_accepted, out_empty_res, out_min_value, out_max_value, out_mean_value,
              out_probability, out_sample_count};
      sb.check_result(seen);
    end
  end

  function automatic int gap_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 96) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  always begin : receiver
    int n;
    @(negedge clk);
    if (hold_req) begin
      hold_req = 1'b0;
      out_stall = 1'b1;
      repeat (LONG_HOLD) @(negedge clk);
    end else begin
      n = rx_idle_on ? gap_len() : 0;
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
    end
    out_stall = 1'b0;
  end

  task automatic send_item(logic [1:0] op, logic signed [hsa_pkg::SAMPLE_W-1:0] value,
                           logic [2:0] cond, logic signed [hsa_pkg::SAMPLE_W-1:0] lo,
                           logic signed [hsa_pkg::SAMPLE_W-1:0] hi);
    int n;
    n = tx_idle_on ? gap_len() : 0;
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_op = op;
    in_sample_value = value;
    in_condition = cond;
    in_lower_limit = lo;
    in_upper_limit = hi;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [hsa_pkg::SAMPLE_W-1:0] rand_limit(int n);
    case ($urandom_range(0, 9))
      0, 1, 2, 3:
        return hsa_pkg::SAMPLE_W'((int'($urandom_range(0, n + 1)) - 1) << hsa_pkg::FRAC_BITS);
      4, 5, 6:
        return hsa_pkg::SAMPLE_W'(int'($urandom_range(0, (n + 2) << hsa_pkg::FRAC_BITS)) - 256);
      7, 8:
        return hsa_pkg::SAMPLE_W'($urandom);
      default:
        return $urandom_range(0, 1) ? hsa_pkg::SAMPLE_W'(65535) : hsa_pkg::SAMPLE_W'(-65536);
    endcase
  endfunction

  task automatic send_random();
    int                                  r;
    int                                  n;
    logic [1:0]                          op;
    logic signed [hsa_pkg::SAMPLE_W-1:0] value;
    n = sb.active_bins();
    r = int'($urandom_range(0, 99));
    if (r < 80) op = hsa_pkg::OP_ADD;
    else if (r < 93) op = hsa_pkg::OP_QUERY;
    else if (r < 96) op = hsa_pkg::OP_CLEAR;
    else op = OP_SPARE;
    r = int'($urandom_range(0, 9));
    if (r < 8 && n > 0)
      value = hsa_pkg::SAMPLE_W'($urandom_range(0, (n << hsa_pkg::FRAC_BITS) - 1));
    else if (r == 8)
      value = hsa_pkg::SAMPLE_W'((n << hsa_pkg::FRAC_BITS) - int'($urandom_range(0, 1)));
    else
      value = hsa_pkg::SAMPLE_W'($urandom);
    send_item(op, value, 3'($urandom_range(0, 7)), rand_limit(n), rand_limit(n));
  endtask

  task automatic settle(int extra);
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.due.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_cfg(hsa_pkg::cfg_reg_t idx, int value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = hsa_pkg::CFG_W'(value);
    sb.write_reg(idx, hsa_pkg::CFG_W'(value));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_item(hsa_pkg::OP_QUERY, '0, hsa_pkg::COND_GE, '0, '0);
    send_item(hsa_pkg::OP_ADD, '0, hsa_pkg::COND_LT, '0, '0);
    send_item(hsa_pkg::OP_ADD, hsa_pkg::SAMPLE_W'(65535), hsa_pkg::COND_NEVER,
              hsa_pkg::SAMPLE_W'(-1), hsa_pkg::SAMPLE_W'(-1));
    send_item(hsa_pkg::OP_ADD, hsa_pkg::SAMPLE_W'(-1), hsa_pkg::COND_LT, '0, '0);
    send_item(hsa_pkg::OP_ADD, hsa_pkg::SAMPLE_W'(-65536), hsa_pkg::COND_LT, '0, '0);
    send_item(hsa_pkg::OP_ADD, hsa_pkg::SAMPLE_W'('h0180), hsa_pkg::COND_LT, '0, '0);
    send_item(hsa_pkg::OP_ADD, hsa_pkg::SAMPLE_W'('h8000), hsa_pkg::COND_LT, '0, '0);
    send_item(hsa_pkg::OP_QUERY, '0, hsa_pkg::COND_LT, hsa_pkg::SAMPLE_W'('h8000), '0);
    send_item(hsa_pkg::OP_QUERY, '0, hsa_pkg::COND_LE, hsa_pkg::SAMPLE_W'('h8000), '0);
    send_item(hsa_pkg::OP_QUERY, '0, hsa_pkg::COND_GT, '0, '0);
    send_item(hsa_pkg::OP_QUERY, '0, hsa_pkg::COND_GE, hsa_pkg::SAMPLE_W'(-65536), '0);
    send_item(hsa_pkg::OP_QUERY, '0, hsa_pkg::COND_IN, hsa_pkg::SAMPLE_W'('h0100),
              hsa_pkg::SAMPLE_W'('hFF00));
    send_item(hsa_pkg::OP_QUERY, '0, hsa_pkg::COND_OUT, hsa_pkg::SAMPLE_W'('h0100),
              hsa_pkg::SAMPLE_W'('h8000));
    send_item(hsa_pkg::OP_QUERY, '0, hsa_pkg::COND_EQ, hsa_pkg::SAMPLE_W'('h0100), '0);
    send_item(hsa_pkg::OP_QUERY, '0, hsa_pkg::COND_NEVER, hsa_pkg::SAMPLE_W'(-65536),
              hsa_pkg::SAMPLE_W'(65535));
    send_item(hsa_pkg::OP_QUERY, '0, hsa_pkg::COND_IN, hsa_pkg::SAMPLE_W'(-65536),
              hsa_pkg::SAMPLE_W'(65535));
    send_item(hsa_pkg::OP_QUERY, '0, hsa_pkg::COND_EQ, hsa_pkg::SAMPLE_W'('h0180), '0);
    send_item(OP_SPARE, hsa_pkg::SAMPLE_W'('h0200), hsa_pkg::COND_LT, '0, '0);
    send_item(hsa_pkg::OP_CLEAR, '0, hsa_pkg::COND_LT, '0, '0);
    send_item(hsa_pkg::OP_QUERY, '0, hsa_pkg::COND_GE, '0, hsa_pkg::SAMPLE_W'(65535));
    send_item(hsa_pkg::OP_ADD, hsa_pkg::SAMPLE_W'('h1234), hsa_pkg::COND_LT, '0, '0);
    send_item(hsa_pkg::OP_QUERY, '0, hsa_pkg::COND_GE, hsa_pkg::SAMPLE_W'(65535), '0);
    settle(4);

    for (int p = 0; p < PHASES; p++) begin
      write_cfg(hsa_pkg::REG_BINS,
                BINS_TAB[p] < 0 ? int'($urandom_range(1, 256)) : BINS_TAB[p]);
      write_cfg(hsa_pkg::REG_SCALE,
                SCALE_TAB[p] < 0 ? int'($urandom_range(0, 1000)) : SCALE_TAB[p]);
      tx_idle_on = (p % 3) != 1;
      rx_idle_on = (p % 3) != 2;
      if (p == 5) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) send_random();
      settle(4);
    end

    settle(TAIL_CYCLES);
    $display("Covered %0d transfers in: %0d samples counted, %0d live queries, %0d results.",
             sb.items, sb.added, sb.queried, sb.results);
    $display("Bin counts 0 to 511 and scales 0 to 1023 were used, with one long hold-off.");
    if (sb.errors == 0) begin
      $display("[histogram_statistics_accumulator] OK");
    end else begin
      $display("[histogram_statistics_accumulator] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("timeout with %0d results outstanding", sb.due.size());
    $display("[histogram_statistics_accumulator] ERROR");
    $finish;
  end

endmodule
